// ----- rtl/ldk_pkg.sv -----
// ldk_pkg: shared widths, constants and types for the ladder keypad debouncer
// no dependencies; imported by every module of the block
package ldk_pkg;

    localparam int NUM_BUTTONS = 6;
    localparam int SAMPLE_W    = 12;
    localparam int QUERY_W     = 3;
    localparam int DBC_W       = 4;
    localparam int TICK_W      = 10;
    localparam int HOLD_W      = 32;
    localparam int SECONDS_W   = 23;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TICK     = CFG_IDX_W'(1);

    typedef struct packed {
        logic                   adc_error;
        logic [NUM_BUTTONS-1:0] hit;
        logic [QUERY_W-1:0]     query;
    } item_t;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

// ----- rtl/ldk_front.sv -----
// ldk_front: accepts sample transactions and sorts each sample into a button window
// depends on ldk_pkg; feeds ldk_fifo
module ldk_front (
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ldk_pkg::SAMPLE_W-1:0]     s_adc_sample,
    input  logic                             s_adc_error,
    input  logic [ldk_pkg::QUERY_W-1:0]      s_query_button,
    input  logic                             q_full,
    output logic                             q_push,
    output ldk_pkg::item_t                   q_item
);
    import ldk_pkg::*;

    localparam logic [SAMPLE_W-1:0] NONE_ABOVE = SAMPLE_W'(3500);
    localparam logic [SAMPLE_W-1:0] UP_LO      = SAMPLE_W'(490);
    localparam logic [SAMPLE_W-1:0] UP_HI      = SAMPLE_W'(580);
    localparam logic [SAMPLE_W-1:0] DOWN_LO    = SAMPLE_W'(1180);
    localparam logic [SAMPLE_W-1:0] DOWN_HI    = SAMPLE_W'(1290);
    localparam logic [SAMPLE_W-1:0] LEFT_HI    = SAMPLE_W'(100);
    localparam logic [SAMPLE_W-1:0] RIGHT_LO   = SAMPLE_W'(1880);
    localparam logic [SAMPLE_W-1:0] RIGHT_HI   = SAMPLE_W'(1990);
    localparam logic [SAMPLE_W-1:0] SIDE_LO    = SAMPLE_W'(2700);
    localparam logic [SAMPLE_W-1:0] SIDE_HI    = SAMPLE_W'(2940);

    logic [NUM_BUTTONS-1:0] hit;

    // windows do not overlap, so at most one bit is set
    always_comb begin
        hit    = '0;
        hit[0] = s_adc_sample > NONE_ABOVE;
        hit[1] = (s_adc_sample >= UP_LO) && (s_adc_sample < UP_HI);
        hit[2] = (s_adc_sample >= DOWN_LO) && (s_adc_sample < DOWN_HI);
        hit[3] = s_adc_sample < LEFT_HI;
        hit[4] = (s_adc_sample >= RIGHT_LO) && (s_adc_sample < RIGHT_HI);
        hit[5] = (s_adc_sample >= SIDE_LO) && (s_adc_sample < SIDE_HI);
    end

    assign s_ready         = !q_full;
    assign q_push          = s_valid && !q_full;
    assign q_item.adc_error = s_adc_error;
    assign q_item.hit       = hit;
    assign q_item.query     = s_query_button;

endmodule

// ----- rtl/ldk_fifo.sv -----
// ldk_fifo: short queue of classified transactions between front and back
// depends on ldk_pkg
module ldk_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ldk_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output ldk_pkg::item_t pop_item
);
    import ldk_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/ldk_back.sv -----
// ldk_back: per-button debounce and hold-time state, result build and ms to seconds
// depends on ldk_pkg; drains ldk_fifo and drives the result channel
module ldk_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ldk_pkg::cfg_wr_t                  cfg,
    input  logic                              q_valid,
    input  ldk_pkg::item_t                    q_item,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ldk_pkg::NUM_BUTTONS-1:0]   m_debounced_mask,
    output logic [ldk_pkg::NUM_BUTTONS-1:0]   m_pressed_mask,
    output logic [ldk_pkg::NUM_BUTTONS-1:0]   m_released_mask,
    output logic [ldk_pkg::SECONDS_W-1:0]     m_query_seconds,
    output logic                              m_query_pressed,
    output logic                              m_query_released
);
    import ldk_pkg::*;

    localparam logic [DBC_W-1:0]  DBC_RESET  = DBC_W'(3);
    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(50);
    // floor(x / 1000) == (x * ceil(2^41 / 1000)) >> 41 for every 32-bit x
    localparam logic [HOLD_W-1:0] DIV_MUL    = 32'd2199023256;
    localparam int                DIV_SHIFT  = 41;

    logic [DBC_W-1:0]       dbc_reg;
    logic [TICK_W-1:0]      tick_reg;

    logic [NUM_BUTTONS-1:0] stable_reg, stable_next;
    logic [NUM_BUTTONS-1:0] prev_reg, prev_next;
    logic [DBC_W-1:0]       cnt_reg  [NUM_BUTTONS];
    logic [DBC_W-1:0]       cnt_next [NUM_BUTTONS];
    logic [HOLD_W-1:0]      hold_reg  [NUM_BUTTONS];
    logic [HOLD_W-1:0]      hold_next [NUM_BUTTONS];

    logic                   s1_valid_reg;
    logic [NUM_BUTTONS-1:0] s1_dm_reg, s1_pm_reg, s1_rm_reg;
    logic [HOLD_W-1:0]      s1_hold_reg;
    logic                   s1_qp_reg, s1_qr_reg;

    logic                   m_valid_reg;
    logic [NUM_BUTTONS-1:0] m_dm_reg, m_pm_reg, m_rm_reg;
    logic [SECONDS_W-1:0]   m_sec_reg;
    logic                   m_qp_reg, m_qr_reg;

    logic                   s1_ready, s2_ready;
    logic                   q_ok;
    logic [HOLD_W-1:0]      q_hold;
    logic [2*HOLD_W-1:0]    prod;

    assign s2_ready = !m_valid_reg || m_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign q_pop    = q_valid && s1_ready;

    // debounce and hold update, all buttons side by side
    always_comb begin
        logic [DBC_W:0]  inc;
        logic [DBC_W-1:0] c;
        logic [HOLD_W:0] sum;
        stable_next = stable_reg;
        prev_next   = prev_reg;
        inc         = '0;
        c           = '0;
        sum         = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            cnt_next[i]  = cnt_reg[i];
            hold_next[i] = hold_reg[i];
        end
        if (!q_item.adc_error) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                if (q_item.hit[i] == stable_reg[i]) begin
                    cnt_next[i] = '0;
                end else begin
                    inc = {1'b0, cnt_reg[i]} + (DBC_W+1)'(1);
                    c   = inc[DBC_W] ? '1 : inc[DBC_W-1:0];
                    if (c >= dbc_reg) begin
                        prev_next[i]   = stable_reg[i];
                        stable_next[i] = q_item.hit[i];
                        cnt_next[i]    = '0;
                    end else begin
                        cnt_next[i]    = c;
                    end
                end
                sum = {1'b0, hold_reg[i]} + (HOLD_W+1)'(tick_reg);
                if (stable_next[i]) begin
                    hold_next[i] = sum[HOLD_W] ? '1 : sum[HOLD_W-1:0];
                end else begin
                    hold_next[i] = '0;
                end
            end
        end
    end

    assign q_ok   = q_item.query < QUERY_W'(NUM_BUTTONS);
    assign q_hold = q_ok ? hold_next[q_item.query] : '0;
    assign prod   = s1_hold_reg * DIV_MUL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbc_reg      <= DBC_RESET;
            tick_reg     <= TICK_RESET;
            stable_reg   <= '0;
            prev_reg     <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                cnt_reg[i]  <= '0;
                hold_reg[i] <= '0;
            end
        end else begin
            if (cfg.valid) begin
                unique case (cfg.index)
                    REG_DEBOUNCE: dbc_reg  <= cfg.data[DBC_W-1:0];
                    REG_TICK:     tick_reg <= cfg.data[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (q_pop) begin
                stable_reg <= stable_next;
                prev_reg   <= prev_next;
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    cnt_reg[i]  <= cnt_next[i];
                    hold_reg[i] <= hold_next[i];
                end
            end
            if (s1_ready) begin
                s1_valid_reg <= q_valid;
            end
            if (s2_ready) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_dm_reg   <= stable_next;
            s1_pm_reg   <= stable_next & ~prev_next;
            s1_rm_reg   <= ~stable_next & prev_next;
            s1_hold_reg <= q_hold;
            s1_qp_reg   <= q_ok && stable_next[q_item.query] && !prev_next[q_item.query];
            s1_qr_reg   <= q_ok && !stable_next[q_item.query] && prev_next[q_item.query];
        end
        if (s2_ready && s1_valid_reg) begin
            m_dm_reg  <= s1_dm_reg;
            m_pm_reg  <= s1_pm_reg;
            m_rm_reg  <= s1_rm_reg;
            m_sec_reg <= prod[DIV_SHIFT +: SECONDS_W];
            m_qp_reg  <= s1_qp_reg;
            m_qr_reg  <= s1_qr_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_debounced_mask = m_dm_reg;
    assign m_pressed_mask   = m_pm_reg;
    assign m_released_mask  = m_rm_reg;
    assign m_query_seconds  = m_sec_reg;
    assign m_query_pressed  = m_qp_reg;
    assign m_query_released = m_qr_reg;

    // held time only accumulates on a committed press
    a_hold_needs_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_reg[0] != '0) |-> stable_reg[0])
        else $error("hold time on a released button");

    // debounce state moves only when a transaction leaves the queue
    a_state_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_pop |=> ($stable(stable_reg) && $stable(prev_reg)))
        else $error("debounce state changed without a transaction");

    // a stalled first stage never takes another transaction
    a_no_pop_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s2_ready) |-> !q_pop)
        else $error("transaction popped into a blocked stage");

    // pressed and released levels exclude each other
    a_press_release_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> ((s1_pm_reg & s1_rm_reg) == '0))
        else $error("button both pressed and released");

endmodule

// ----- rtl/ladder_keypad_debouncer.sv -----
// ladder_keypad_debouncer: top level of the resistor-ladder keypad debouncer
// depends on ldk_pkg, ldk_front, ldk_fifo and ldk_back
//
// One transaction per cycle is sustained in both directions while m_ready stays high.
// A sample is taken whenever s_ready is high (the queue has room); its result is held
// in the queue while the debounce and hold update is worked out, then registered in
// the first stage, and registered once more with m_valid after the reciprocal multiply
// that turns milliseconds into whole seconds. The queue (FIFO_DEPTH entries) absorbs
// stalls on the result side. Configuration writes are always taken (cfg_ready is
// tied high) and take effect for every sample that leaves the queue after the write.
module ladder_keypad_debouncer #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ldk_pkg::SAMPLE_W-1:0]       s_adc_sample,
    input  logic                               s_adc_error,
    input  logic [ldk_pkg::QUERY_W-1:0]        s_query_button,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ldk_pkg::NUM_BUTTONS-1:0]    m_debounced_mask,
    output logic [ldk_pkg::NUM_BUTTONS-1:0]    m_pressed_mask,
    output logic [ldk_pkg::NUM_BUTTONS-1:0]    m_released_mask,
    output logic [ldk_pkg::SECONDS_W-1:0]      m_query_seconds,
    output logic                               m_query_pressed,
    output logic                               m_query_released,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ldk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ldk_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ldk_pkg::*;

    logic    q_full, q_push, q_pop, q_valid;
    item_t   push_item, pop_item;
    cfg_wr_t cfg;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    ldk_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_adc_sample   (s_adc_sample),
        .s_adc_error    (s_adc_error),
        .s_query_button (s_query_button),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (push_item)
    );

    ldk_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (pop_item)
    );

    ldk_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .q_valid          (q_valid),
        .q_item           (pop_item),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_debounced_mask (m_debounced_mask),
        .m_pressed_mask   (m_pressed_mask),
        .m_released_mask  (m_released_mask),
        .m_query_seconds  (m_query_seconds),
        .m_query_pressed  (m_query_pressed),
        .m_query_released (m_query_released)
    );

endmodule
